>>> sv/dcea_pkg.sv
// Shared widths, codes and structs of the DRAM command energy accumulator.
`timescale 1ns / 1ps
package dcea_pkg;

  localparam int NUM_BANKS  = 16;
  localparam int KINDS      = 6;
  localparam int KIND_W     = 3;
  localparam int STAMP_W    = 48;
  localparam int BANK_W     = 4;
  localparam int BURST_W    = 6;
  localparam int RATE_W     = 24;
  localparam int RCYC_W     = 12;
  localparam int DUR_W      = 12;
  localparam int EN_W       = RATE_W + DUR_W;
  localparam int ACC_W      = 64;
  localparam int CNT_W      = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // durations in clocks
  localparam logic [DUR_W-1:0] ACT_DUR = DUR_W'(22);
  localparam logic [DUR_W-1:0] RD_BASE = DUR_W'(16);
  localparam logic [DUR_W-1:0] WR_BASE = DUR_W'(12);
  localparam logic [DUR_W-1:0] IDLE_DUR = DUR_W'(1);
  localparam logic [RCYC_W-1:0] RCYC_RESET = RCYC_W'(312);

  typedef enum logic [KIND_W-1:0] {
    CMD_ACT  = 3'd0,
    CMD_PRE  = 3'd1,
    CMD_RD   = 3'd2,
    CMD_WR   = 3'd3,
    CMD_REF  = 3'd4,
    CMD_IDLE = 3'd5
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACT_RATE  = 3'd0,
    REG_IDLE_RATE = 3'd1,
    REG_OPEN_RATE = 3'd2,
    REG_RD_RATE   = 3'd3,
    REG_WR_RATE   = 3'd4,
    REG_REF_RATE  = 3'd5,
    REG_REF_CYC   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [RATE_W-1:0] act_rate;
    logic [RATE_W-1:0] idle_rate;
    logic [RATE_W-1:0] open_rate;
    logic [RATE_W-1:0] rd_rate;
    logic [RATE_W-1:0] wr_rate;
    logic [RATE_W-1:0] ref_rate;
    logic [RCYC_W-1:0] ref_cycles;
  } cfg_t;

  typedef struct packed {
    logic [KIND_W-1:0]  command;
    logic [STAMP_W-1:0] stamp;
    logic [BANK_W-1:0]  bank;
    logic [BURST_W-1:0] burst_len;
  } item_t;

  // stage A result handed to the accumulators
  typedef struct packed {
    logic               known;
    logic               peak_en;
    logic [KIND_W-1:0]  kind;
    logic [EN_W-1:0]    energy;
    logic [RATE_W-1:0]  rate;
    logic [STAMP_W-1:0] stamp;
    logic               any_open;
  } eval_t;

endpackage

>>> sv/dcea_if.sv
// Request channels of the energy accumulator: command in, result out, register write.
`timescale 1ns / 1ps
interface dcea_in_if;
  import dcea_pkg::*;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  command;
  logic [STAMP_W-1:0] stamp;
  logic [BANK_W-1:0]  bank;
  logic [BURST_W-1:0] burst_len;
  modport source (output valid, command, stamp, bank, burst_len, input ready);
  modport sink   (input valid, command, stamp, bank, burst_len, output ready);
endinterface

interface dcea_out_if;
  import dcea_pkg::*;
  logic               valid;
  logic               ready;
  logic [ACC_W-1:0]   total_energy;
  logic [ACC_W-1:0]   act_energy;
  logic [ACC_W-1:0]   pre_energy;
  logic [ACC_W-1:0]   rd_energy;
  logic [ACC_W-1:0]   wr_energy;
  logic [ACC_W-1:0]   ref_energy;
  logic [ACC_W-1:0]   bg_energy;
  logic [RATE_W-1:0]  peak_rate;
  logic [STAMP_W-1:0] latest_stamp;
  logic [CNT_W-1:0]   kind_count;
  logic               any_open;
  modport source (output valid, total_energy, act_energy, pre_energy, rd_energy,
                  wr_energy, ref_energy, bg_energy, peak_rate, latest_stamp,
                  kind_count, any_open, input ready);
  modport sink   (input valid, total_energy, act_energy, pre_energy, rd_energy,
                  wr_energy, ref_energy, bg_energy, peak_rate, latest_stamp,
                  kind_count, any_open, output ready);
endinterface

interface dcea_cfg_if;
  import dcea_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/dcea_cfg_regs.sv
// Per-clock energy rates and refresh length, written through the register channel.
`timescale 1ns / 1ps
module dcea_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  dcea_cfg_if.sink      cfg_chan,
  output dcea_pkg::cfg_t cfg
);
  import dcea_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_chan.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_chan.valid) begin
      case (cfg_chan.index)
        REG_ACT_RATE:  cfg_nxt.act_rate   = cfg_chan.data;
        REG_IDLE_RATE: cfg_nxt.idle_rate  = cfg_chan.data;
        REG_OPEN_RATE: cfg_nxt.open_rate  = cfg_chan.data;
        REG_RD_RATE:   cfg_nxt.rd_rate    = cfg_chan.data;
        REG_WR_RATE:   cfg_nxt.wr_rate    = cfg_chan.data;
        REG_REF_RATE:  cfg_nxt.ref_rate   = cfg_chan.data;
        REG_REF_CYC:   cfg_nxt.ref_cycles = cfg_chan.data[RCYC_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // rates clear, refresh length back to its default (lowest field)
      cfg_r <= cfg_t'({(6 * RATE_W)'(0), RCYC_RESET});
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> sv/dcea_cmd_eval.sv
// Stage A: bank open table, rate and duration select, energy product.
`timescale 1ns / 1ps
module dcea_cmd_eval (
  input  logic           clk,
  input  logic           rst_n,
  input  dcea_pkg::cfg_t  cfg,
  input  logic           in_valid,
  input  dcea_pkg::item_t item,
  input  logic           down_free,
  output logic           up_free,
  output logic           ev_valid,
  output dcea_pkg::eval_t ev
);
  import dcea_pkg::*;

  logic                 ev_valid_r;
  eval_t                ev_r;
  eval_t                ev_nxt;
  logic [NUM_BANKS-1:0] open_r;
  logic [NUM_BANKS-1:0] open_nxt;
  logic                 move;
  logic                 known;
  logic [RATE_W-1:0]    rate;
  logic [DUR_W-1:0]     dur;

  assign up_free  = !ev_valid_r || down_free;
  assign move     = in_valid && up_free;
  assign ev_valid = ev_valid_r;
  assign ev       = ev_r;
  assign known    = (item.command < KIND_W'(KINDS));

  always_comb begin
    rate = '0;
    dur  = '0;
    case (item.command)
      CMD_ACT: begin
        rate = cfg.act_rate;
        dur  = ACT_DUR;
      end
      CMD_PRE: begin
        rate = cfg.idle_rate;
        dur  = ACT_DUR;
      end
      CMD_RD: begin
        rate = cfg.rd_rate;
        dur  = RD_BASE + DUR_W'(item.burst_len >> 1);
      end
      CMD_WR: begin
        rate = cfg.wr_rate;
        dur  = WR_BASE + DUR_W'(item.burst_len >> 1);
      end
      CMD_REF: begin
        rate = cfg.ref_rate;
        dur  = DUR_W'(cfg.ref_cycles);
      end
      CMD_IDLE: begin
        // background rate depends on bank state before this tick
        rate = (|open_r) ? cfg.open_rate : cfg.idle_rate;
        dur  = IDLE_DUR;
      end
      default: begin
        rate = '0;
        dur  = '0;
      end
    endcase
  end

  always_comb begin
    open_nxt = open_r;
    for (int i = 0; i < NUM_BANKS; i++) begin
      if (32'(item.bank) == i) begin
        if (item.command == CMD_ACT) open_nxt[i] = 1'b1;
        else if (item.command == CMD_PRE) open_nxt[i] = 1'b0;
      end
    end
  end

  always_comb begin
    ev_nxt.known    = known;
    ev_nxt.peak_en  = known && (item.command != CMD_IDLE);
    ev_nxt.kind     = item.command;
    ev_nxt.energy   = EN_W'(rate) * EN_W'(dur);
    ev_nxt.rate     = rate;
    ev_nxt.stamp    = item.stamp;
    ev_nxt.any_open = |open_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_valid_r <= 1'b0;
      open_r     <= '0;
    end else begin
      if (up_free) ev_valid_r <= in_valid;
      if (move) open_r <= open_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (move) ev_r <= ev_nxt;
  end

endmodule

>>> sv/dcea_accum.sv
// Stage B: saturating energy and count accumulators, peak, latest stamp, result register.
`timescale 1ns / 1ps
module dcea_accum (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           ev_valid,
  input  dcea_pkg::eval_t ev,
  output logic           free,
  dcea_out_if.source     out_chan
);
  import dcea_pkg::*;

  logic [ACC_W-1:0]   kind_en_r [KINDS];
  logic [ACC_W-1:0]   kind_en_nxt [KINDS];
  logic [CNT_W-1:0]   kind_cnt_r [KINDS];
  logic [CNT_W-1:0]   kind_cnt_nxt [KINDS];
  logic [ACC_W-1:0]   sum_r;
  logic [ACC_W-1:0]   sum_nxt;
  logic [RATE_W-1:0]  peak_r;
  logic [RATE_W-1:0]  peak_nxt;
  logic [STAMP_W-1:0] latest_r;
  logic [STAMP_W-1:0] latest_nxt;
  logic [CNT_W-1:0]   count_out_r;
  logic [CNT_W-1:0]   count_out_nxt;
  logic               any_open_r;
  logic               out_valid_r;
  logic               move;
  logic [ACC_W-1:0]   sel_en;
  logic [CNT_W-1:0]   sel_cnt;
  logic [ACC_W:0]     kind_sum;
  logic [ACC_W:0]     tot_sum;
  logic [ACC_W-1:0]   kind_new;
  logic [CNT_W-1:0]   cnt_new;

  assign free = !out_valid_r || out_chan.ready;
  assign move = ev_valid && free;

  always_comb begin
    sel_en  = '0;
    sel_cnt = '0;
    for (int k = 0; k < KINDS; k++) begin
      if (32'(ev.kind) == k) begin
        sel_en  = kind_en_r[k];
        sel_cnt = kind_cnt_r[k];
      end
    end
    kind_sum = {1'b0, sel_en} + (ACC_W + 1)'(ev.energy);
    tot_sum  = {1'b0, sum_r} + (ACC_W + 1)'(ev.energy);
    kind_new = kind_sum[ACC_W] ? '1 : kind_sum[ACC_W-1:0];
    cnt_new  = (&sel_cnt) ? sel_cnt : sel_cnt + CNT_W'(1);

    kind_en_nxt   = kind_en_r;
    kind_cnt_nxt  = kind_cnt_r;
    sum_nxt       = sum_r;
    peak_nxt      = peak_r;
    latest_nxt    = latest_r;
    count_out_nxt = '0;
    if (ev.known) begin
      for (int k = 0; k < KINDS; k++) begin
        if (32'(ev.kind) == k) begin
          kind_en_nxt[k]  = kind_new;
          kind_cnt_nxt[k] = cnt_new;
        end
      end
      sum_nxt       = tot_sum[ACC_W] ? '1 : tot_sum[ACC_W-1:0];
      count_out_nxt = cnt_new;
      if (ev.peak_en && (ev.rate > peak_r)) peak_nxt = ev.rate;
      if (ev.stamp > latest_r) latest_nxt = ev.stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sum_r       <= '0;
      peak_r      <= '0;
      latest_r    <= '0;
      for (int k = 0; k < KINDS; k++) begin
        kind_en_r[k]  <= '0;
        kind_cnt_r[k] <= '0;
      end
    end else begin
      if (free) out_valid_r <= ev_valid;
      if (move) begin
        sum_r      <= sum_nxt;
        peak_r     <= peak_nxt;
        latest_r   <= latest_nxt;
        kind_en_r  <= kind_en_nxt;
        kind_cnt_r <= kind_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      count_out_r <= count_out_nxt;
      any_open_r  <= ev.any_open;
    end
  end

  // state holds still while a result waits, so it doubles as the result payload
  assign out_chan.valid        = out_valid_r;
  assign out_chan.total_energy = sum_r;
  assign out_chan.act_energy   = kind_en_r[CMD_ACT];
  assign out_chan.pre_energy   = kind_en_r[CMD_PRE];
  assign out_chan.rd_energy    = kind_en_r[CMD_RD];
  assign out_chan.wr_energy    = kind_en_r[CMD_WR];
  assign out_chan.ref_energy   = kind_en_r[CMD_REF];
  assign out_chan.bg_energy    = kind_en_r[CMD_IDLE];
  assign out_chan.peak_rate    = peak_r;
  assign out_chan.latest_stamp = latest_r;
  assign out_chan.kind_count   = count_out_r;
  assign out_chan.any_open     = any_open_r;

endmodule

>>> sv/dram_command_energy_accumulator.sv
// Top level of the DRAM command energy accumulator.
`timescale 1ns / 1ps
// Usage:
//   in_chan  : one request per DRAM command or idle tick (command, stamp, bank,
//              burst_len). Accepted on valid && ready.
//   out_chan : exactly one result request per input request, in order: total and
//              per-kind saturating energies (1/256 pJ), peak non-idle rate,
//              latest stamp, count of this request's kind, any-bank-open flag.
//   cfg_chan : register writes (index 0..6), always ready. Write only while idle.
// Path: the input register loads at the accept edge, then the energy product
//   register, then the accumulator/result register, which drives result valid.
// Throughput: one request per cycle while out_chan.ready stays high; the accumulate
//   loop closes in the accumulator stage, the 24x12 product in the stage before it.
// Reset (rst_n low, synchronous): all energies, counts, peak and stamp clear,
//   every bank closed, refresh length back to its default RCYC_RESET, rates to zero.
// Receiver stall: the result holds in the output register; the two stages in
//   front keep taking requests until both are full, then in_chan.ready drops.
module dram_command_energy_accumulator (
  input  logic      clk,
  input  logic      rst_n,
  dcea_in_if.sink   in_chan,
  dcea_out_if.source out_chan,
  dcea_cfg_if.sink  cfg_chan
);
  import dcea_pkg::*;

  cfg_t  cfg;
  logic  in_valid_r;
  item_t in_item_r;
  logic  a_free;
  logic  ev_valid;
  eval_t ev;
  logic  b_free;

  dcea_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg      (cfg)
  );

  // input register
  assign in_chan.ready = !in_valid_r || a_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_item_r.command   <= in_chan.command;
      in_item_r.stamp     <= in_chan.stamp;
      in_item_r.bank      <= in_chan.bank;
      in_item_r.burst_len <= in_chan.burst_len;
    end
  end

  // rate select, bank tracking and energy product
  dcea_cmd_eval u_eval (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid_r),
    .item      (in_item_r),
    .down_free (b_free),
    .up_free   (a_free),
    .ev_valid  (ev_valid),
    .ev        (ev)
  );

  // saturating accumulation and result register
  dcea_accum u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .ev_valid (ev_valid),
    .ev       (ev),
    .free     (b_free),
    .out_chan (out_chan)
  );

endmodule
